// File: src/rasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rasp_pkg;

    // result command codes
    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;

    // aperture shape codes
    localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
    localparam logic [1:0] SHAPE_RECT   = 2'd1;

    // configuration register indexes
    localparam logic [1:0] REG_SHAPE       = 2'd0;
    localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HALF_HEIGHT = 2'd2;

    // input kinds
    localparam logic KIND_START = 1'b0;

    // comparison of new against cached coordinate
    localparam logic [1:0] CMP_GREATER = 2'd0;
    localparam logic [1:0] CMP_LESS    = 2'd1;
    localparam logic [1:0] CMP_EQUAL   = 2'd2;

    // corner code: bit 2 new point, bit 1 x plus half width, bit 0 y plus half height
    localparam logic [2:0] CORNER_COUNT [0:8] = '{
        3'd6, 3'd6, 3'd4, 3'd6, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam logic [2:0] CORNER_CODE [0:8][0:5] = '{
        '{3'd0, 3'd2, 3'd6, 3'd7, 3'd5, 3'd1},
        '{3'd0, 3'd4, 3'd6, 3'd7, 3'd3, 3'd1},
        '{3'd0, 3'd6, 3'd7, 3'd1, 3'd0, 3'd0},
        '{3'd4, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5},
        '{3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5},
        '{3'd4, 3'd2, 3'd3, 3'd5, 3'd0, 3'd0},
        '{3'd0, 3'd2, 3'd7, 3'd5, 3'd0, 3'd0},
        '{3'd4, 3'd6, 3'd3, 3'd1, 3'd0, 3'd0},
        '{3'd4, 3'd6, 3'd3, 3'd1, 3'd0, 3'd0}
    };

    typedef enum logic [1:0] {
        JOB_PASS,
        JOB_ERROR,
        JOB_RECT
    } job_mode_t;

    typedef struct packed {
        job_mode_t          mode;
        logic [1:0]         cmd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [3:0]         row;
    } job_t;

endpackage
`default_nettype wire

// File: src/rasp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rasp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic [1:0]         shape,
    input  wire logic               queue_full,
    output logic                    push,
    output rasp_pkg::job_t          job
);
    import rasp_pkg::*;

    logic signed [31:0] cached_x_reg, cached_x_next;
    logic signed [31:0] cached_y_reg, cached_y_next;
    logic               accept;
    logic [1:0]         xcase, ycase;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        if (point_x > cached_x_reg)
            xcase = CMP_GREATER;
        else if (point_x < cached_x_reg)
            xcase = CMP_LESS;
        else
            xcase = CMP_EQUAL;
        if (point_y > cached_y_reg)
            ycase = CMP_GREATER;
        else if (point_y < cached_y_reg)
            ycase = CMP_LESS;
        else
            ycase = CMP_EQUAL;
    end

    always_comb
    begin
        job.px  = point_x;
        job.py  = point_y;
        job.cx  = cached_x_reg;
        job.cy  = cached_y_reg;
        job.row = {2'b00, xcase} * 4'd3 + {2'b00, ycase};
        job.cmd = (kind == KIND_START) ? CMD_MOVE : CMD_LINE;
        if (shape == SHAPE_CIRCLE)
            job.mode = JOB_PASS;
        else if (shape == SHAPE_RECT)
            job.mode = JOB_RECT;
        else
            job.mode = JOB_ERROR;

        // a rectangle path start only loads the cache
        push = accept && !(shape == SHAPE_RECT && kind == KIND_START);

        cached_x_next = cached_x_reg;
        cached_y_next = cached_y_reg;
        if (accept && shape == SHAPE_RECT)
        begin
            cached_x_next = point_x;
            cached_y_next = point_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cached_x_reg <= '0;
            cached_y_reg <= '0;
        end
        else
        begin
            cached_x_reg <= cached_x_next;
            cached_y_reg <= cached_y_next;
        end
    end

endmodule
`default_nettype wire

// File: src/rasp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module rasp_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rasp_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output rasp_pkg::job_t       head_job
);
    import rasp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: src/rasp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rasp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire rasp_pkg::job_t     head_job,
    output logic                    pop,
    input  wire logic [23:0]        half_width,
    input  wire logic [23:0]        half_height,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              command,
    output logic signed [33:0]      vertex_x,
    output logic signed [33:0]      vertex_y,
    output logic                    last
);
    import rasp_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          command_reg, command_next;
    logic signed [33:0]  vertex_x_reg, vertex_x_next;
    logic signed [33:0]  vertex_y_reg, vertex_y_next;
    logic                last_reg, last_next;
    logic [2:0]          idx_reg, idx_next;
    logic                advance;
    logic [2:0]          slot;
    logic [2:0]          code;
    logic signed [33:0]  bx, by, wx, hy;

    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign vertex_x  = vertex_x_reg;
    assign vertex_y  = vertex_y_reg;
    assign last      = last_reg;

    // output register free or being drained this cycle
    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        // the move and the first line both go to the first corner
        slot = (idx_reg == 3'd0) ? 3'd0 : idx_reg - 3'd1;
        code = CORNER_CODE[head_job.row][slot];
        bx   = code[2] ? 34'(head_job.px) : 34'(head_job.cx);
        by   = code[2] ? 34'(head_job.py) : 34'(head_job.cy);
        wx   = $signed({10'b0, half_width});
        hy   = $signed({10'b0, half_height});

        out_valid_next = out_valid_reg;
        command_next   = command_reg;
        vertex_x_next  = vertex_x_reg;
        vertex_y_next  = vertex_y_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;

        if (advance)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                case (head_job.mode)
                    JOB_PASS:
                    begin
                        command_next  = head_job.cmd;
                        vertex_x_next = 34'(head_job.px);
                        vertex_y_next = 34'(head_job.py);
                        last_next     = 1'b1;
                    end
                    JOB_RECT:
                    begin
                        command_next  = (idx_reg == 3'd0) ? CMD_MOVE : CMD_LINE;
                        vertex_x_next = code[1] ? bx + wx : bx - wx;
                        vertex_y_next = code[0] ? by + hy : by - hy;
                        last_next     = (idx_reg == CORNER_COUNT[head_job.row]);
                    end
                    default:
                    begin
                        command_next  = CMD_ERROR;
                        vertex_x_next = '0;
                        vertex_y_next = '0;
                        last_next     = 1'b1;
                    end
                endcase
                // drop the job after its final result, else step to the next corner
                if (last_next)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg  <= command_next;
        vertex_x_reg <= vertex_x_next;
        vertex_y_reg <= vertex_y_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule
`default_nettype wire

// File: src/rect_aperture_stroke_outline.sv
`timescale 1ns / 1ps
`default_nettype none
// Rectangular-pen stroke outliner. Path points enter one item per cycle while
// the job queue is not full, each marked as a path start or a line-to. With
// the circle aperture every point leaves as one move or line command; with the
// rectangle aperture a path start only loads the cached point, and a line-to
// emits the outline of the rectangle swept from the cached point to the new
// one: a move plus 4 or 6 line commands (5 or 7 results), last set on the
// final one. Any other aperture code gives a single error result per item. The
// front stage classifies items and keeps the cached point, a small job queue
// (QUEUE_DEPTH entries) sits between it and the back stage, which expands a job
// into one result per cycle, unless stalled, into an output register. So a
// circle or error item gives one result, a rectangle line-to 5 or 7, and a path
// start in rectangle mode none; the result channel, one result per cycle unless
// stalled, sets the pace. Input stall rises only while the job queue is full.
// Write the configuration registers only while the block is idle.
module rect_aperture_stroke_outline #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              command,
    output logic signed [33:0]      vertex_x,
    output logic signed [33:0]      vertex_y,
    output logic                    last
);
    import rasp_pkg::*;

    logic [1:0]  shape_reg, shape_next;
    logic [23:0] half_width_reg, half_width_next;
    logic [23:0] half_height_reg, half_height_next;

    logic        push;
    job_t        push_job;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    job_t        head_job;

    // configuration registers; writes to an unused index are ignored
    always_comb
    begin
        shape_next       = shape_reg;
        half_width_next  = half_width_reg;
        half_height_next = half_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SHAPE:       shape_next       = cfg_data[1:0];
                REG_HALF_WIDTH:  half_width_next  = cfg_data;
                REG_HALF_HEIGHT: half_height_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg       <= SHAPE_CIRCLE;
            half_width_reg  <= '0;
            half_height_reg <= '0;
        end
        else
        begin
            shape_reg       <= shape_next;
            half_width_reg  <= half_width_next;
            half_height_reg <= half_height_next;
        end
    end

    // classify items, hold the cached point, build jobs
    rasp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .point_x    (point_x),
        .point_y    (point_y),
        .shape      (shape_reg),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // decouple the front from the back
    rasp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // expand each job into results, one per cycle while the output is not stalled
    rasp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .command     (command),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last        (last)
    );

endmodule
`default_nettype wire

// File: src/rasp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rasp_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         command,
    input  wire logic signed [33:0] vertex_x,
    input  wire logic signed [33:0] vertex_y,
    input  wire logic               last
);
    import rasp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command) && $stable(vertex_x)
            && $stable(vertex_y) && $stable(last))
        else $error("stalled result changed");

    // an error result stands alone at the origin
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == CMD_ERROR |-> last && vertex_x == '0 && vertex_y == '0)
        else $error("malformed error result");

    // inside an outline every result after the first is a line
    a_outline_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> !out_valid || command == CMD_LINE)
        else $error("outline continues with a non-line command");

    // a result that is not last starts or continues an outline
    a_not_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> command == CMD_MOVE || command == CMD_LINE)
        else $error("unexpected command in an outline");

endmodule

bind rect_aperture_stroke_outline rasp_checker u_rasp_checker (.*);
`default_nettype wire
